### design/pfsa_pkg.sv
// Shared widths, reset value, and command, state and status types of the free-slot allocator.
package pfsa_pkg;

    localparam int POS_W   = 13;
    localparam int SLOT_W  = 13;
    localparam int COUNT_W = 13;

    localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 13'd4096;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_START,
        OP_DESC,
        OP_PICK,
        OP_DESC2,
        OP_ASC
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DESC,
        ST_PICK,
        ST_DESC2,
        ST_ASC,
        ST_FIN
    } state_t;

    typedef struct packed {
        op_t  op;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic zero_bound;
        logic root_full;
        logic stop;
        logic leaf_hit;
        logic cand_ok;
        logic cand_leaf;
        logic asc_more;
        logic out_free;
    } status_t;

endpackage

### design/pfsa_ctrl.sv
// Sequencing state machine of the free-slot allocator: clear, descend, backtrack, update, publish.
module pfsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfsa_pkg::status_t  status,
    output pfsa_pkg::cmd_t     cmd
);

    pfsa_pkg::state_t state_reg;
    pfsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfsa_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = pfsa_pkg::OP_NONE;
        cmd.publish = 1'b0;
        in_ready    = 1'b0;
        case (state_reg)
            pfsa_pkg::ST_CLEAR:
            begin
                cmd.op = pfsa_pkg::OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = pfsa_pkg::ST_IDLE;
                end
            end
            pfsa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = pfsa_pkg::OP_ACCEPT;
                    state_next = pfsa_pkg::ST_START;
                end
            end
            pfsa_pkg::ST_START:
            begin
                cmd.op = pfsa_pkg::OP_START;
                if (status.zero_bound || status.root_full)
                begin
                    state_next = pfsa_pkg::ST_FIN;
                end
                else
                begin
                    state_next = pfsa_pkg::ST_DESC;
                end
            end
            pfsa_pkg::ST_DESC:
            begin
                cmd.op = pfsa_pkg::OP_DESC;
                if (status.stop)
                begin
                    state_next = pfsa_pkg::ST_PICK;
                end
                else if (status.leaf_hit)
                begin
                    state_next = pfsa_pkg::ST_ASC;
                end
            end
            pfsa_pkg::ST_PICK:
            begin
                cmd.op = pfsa_pkg::OP_PICK;
                if (!status.cand_ok)
                begin
                    state_next = pfsa_pkg::ST_FIN;
                end
                else if (status.cand_leaf)
                begin
                    state_next = pfsa_pkg::ST_ASC;
                end
                else
                begin
                    state_next = pfsa_pkg::ST_DESC2;
                end
            end
            pfsa_pkg::ST_DESC2:
            begin
                cmd.op = pfsa_pkg::OP_DESC2;
                if (status.leaf_hit)
                begin
                    state_next = pfsa_pkg::ST_ASC;
                end
            end
            pfsa_pkg::ST_ASC:
            begin
                cmd.op = pfsa_pkg::OP_ASC;
                if (!status.asc_more)
                begin
                    state_next = pfsa_pkg::ST_FIN;
                end
            end
            pfsa_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = pfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfsa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/pfsa_datapath.sv
// Datapath of the free-slot allocator: summary tree memory, walk registers and result registers.
module pfsa_datapath #(
    parameter int SLOTS = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfsa_pkg::cmd_t                 cmd,
    output pfsa_pkg::status_t              status,
    input  logic [pfsa_pkg::POS_W-1:0]     position,
    input  logic                           cfg_valid,
    input  logic [pfsa_pkg::COUNT_W-1:0]   slot_count,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           found,
    output logic [pfsa_pkg::SLOT_W-1:0]    slot
);

    localparam int LEVELS    = $clog2(SLOTS);
    localparam int AW        = LEVELS;
    localparam int NW        = LEVELS + 1;
    localparam int SW        = pfsa_pkg::SLOT_W;
    localparam int CW        = pfsa_pkg::COUNT_W;
    localparam int PW        = pfsa_pkg::POS_W;
    localparam int MW0       = (CW > NW) ? CW : NW;
    localparam int CMP_W     = (PW > MW0) ? PW : MW0;
    localparam int MEM_DEPTH = 1 << LEVELS;

    localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);
    localparam logic [AW-1:0]    ROOT    = AW'(1);

    // Word p holds the full bits of heap nodes 2p (bit 0) and 2p+1 (bit 1).
    logic [1:0] tree_mem [MEM_DEPTH];

    logic [CW-1:0] slot_count_reg, slot_count_next;
    logic [AW-1:0] bound_reg,      bound_next;
    logic          zero_reg,       zero_next;
    logic [NW-1:0] node_reg,       node_next;
    logic [NW-1:0] cand_reg,       cand_next;
    logic          cand_valid_reg, cand_valid_next;
    logic [1:0]    rd_reg;
    logic          root_full_reg,  root_full_next;
    logic [AW-1:0] clr_cnt_reg,    clr_cnt_next;
    logic          res_found_reg,  res_found_next;
    logic [SW-1:0] res_slot_reg,   res_slot_next;
    logic          out_valid_reg,  out_valid_next;
    logic          found_reg,      found_next;
    logic [SW-1:0] slot_reg,       slot_next;

    logic [AW-1:0] raddr;
    logic          mem_we;
    logic [AW-1:0] waddr;
    logic [1:0]    wdata;

    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] bnd;
    logic             b_path;
    logic             child_full;
    logic [NW-1:0]    c_path;
    logic             b_right;
    logic [NW-1:0]    c_right;
    logic             leaf_next;
    logic [AW-1:0]    parent;
    logic [1:0]       merged;
    logic             merged_full;

    function automatic logic [SW-1:0] slot_of(input logic [NW-1:0] leaf);
        logic [NW-1:0] s;
        s = {1'b0, leaf[AW-1:0]} + NW'(1);
        return SW'(s);
    endfunction

    // Clamp the request bound to the slot count and to the tree size.
    always_comb
    begin
        limit = (CMP_W'(slot_count_reg) > SLOTS_C) ? SLOTS_C : CMP_W'(slot_count_reg);
        bnd   = (CMP_W'(position) > limit) ? limit : CMP_W'(position);
    end

    assign b_path      = bound_reg[AW-1];
    assign child_full  = rd_reg[b_path];
    assign c_path      = {node_reg[AW-1:0], b_path};
    assign b_right     = ~rd_reg[1];
    assign c_right     = {node_reg[AW-1:0], b_right};
    assign leaf_next   = node_reg[AW-1];
    assign parent      = node_reg[NW-1:1];
    assign merged      = rd_reg | (node_reg[0] ? 2'b10 : 2'b01);
    assign merged_full = &merged;

    assign status.clear_last = (clr_cnt_reg == {AW{1'b1}});
    assign status.zero_bound = zero_reg;
    assign status.root_full  = root_full_reg;
    assign status.stop       = child_full;
    assign status.leaf_hit   = leaf_next;
    assign status.cand_ok    = cand_valid_reg;
    assign status.cand_leaf  = cand_reg[NW-1];
    assign status.asc_more   = merged_full && (parent != ROOT);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        slot_count_next = slot_count_reg;
        bound_next      = bound_reg;
        zero_next       = zero_reg;
        node_next       = node_reg;
        cand_next       = cand_reg;
        cand_valid_next = cand_valid_reg;
        root_full_next  = root_full_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_found_next  = res_found_reg;
        res_slot_next   = res_slot_reg;
        raddr           = node_reg[AW-1:0];
        mem_we          = 1'b0;
        waddr           = parent;
        wdata           = merged;

        if (cfg_valid)
        begin
            slot_count_next = slot_count;
        end

        case (cmd.op)
            pfsa_pkg::OP_CLEAR:
            begin
                mem_we       = 1'b1;
                waddr        = clr_cnt_reg;
                wdata        = 2'b00;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            pfsa_pkg::OP_ACCEPT:
            begin
                bound_next     = AW'(bnd - CMP_W'(1));
                zero_next      = (bnd == '0);
                res_found_next = 1'b0;
                res_slot_next  = '0;
            end
            pfsa_pkg::OP_START:
            begin
                node_next       = NW'(1);
                cand_valid_next = 1'b0;
                raddr           = ROOT;
            end
            pfsa_pkg::OP_DESC:
            begin
                // Remember the deepest free left sibling for the backtrack.
                if (b_path && !rd_reg[0])
                begin
                    cand_next       = {node_reg[AW-1:0], 1'b0};
                    cand_valid_next = 1'b1;
                end
                if (!child_full)
                begin
                    node_next  = c_path;
                    bound_next = bound_reg << 1;
                    if (leaf_next)
                    begin
                        raddr          = node_reg[AW-1:0];
                        res_found_next = 1'b1;
                        res_slot_next  = slot_of(c_path);
                    end
                    else
                    begin
                        raddr = c_path[AW-1:0];
                    end
                end
            end
            pfsa_pkg::OP_PICK:
            begin
                if (cand_valid_reg)
                begin
                    node_next = cand_reg;
                    if (cand_reg[NW-1])
                    begin
                        raddr          = cand_reg[NW-1:1];
                        res_found_next = 1'b1;
                        res_slot_next  = slot_of(cand_reg);
                    end
                    else
                    begin
                        raddr = cand_reg[AW-1:0];
                    end
                end
            end
            pfsa_pkg::OP_DESC2:
            begin
                // Prefer the right child whenever it still has room.
                node_next = c_right;
                if (leaf_next)
                begin
                    raddr          = node_reg[AW-1:0];
                    res_found_next = 1'b1;
                    res_slot_next  = slot_of(c_right);
                end
                else
                begin
                    raddr = c_right[AW-1:0];
                end
            end
            pfsa_pkg::OP_ASC:
            begin
                mem_we = 1'b1;
                if (merged_full)
                begin
                    if (parent == ROOT)
                    begin
                        root_full_next = 1'b1;
                    end
                    else
                    begin
                        node_next = {1'b0, parent};
                        raddr     = parent >> 1;
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        found_next = found_reg;
        slot_next  = slot_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
            found_next     = res_found_reg;
            slot_next      = res_slot_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= pfsa_pkg::SLOT_COUNT_RST;
            cand_valid_reg <= 1'b0;
            root_full_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            cand_valid_reg <= cand_valid_next;
            root_full_reg  <= root_full_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg     <= bound_next;
        zero_reg      <= zero_next;
        node_reg      <= node_next;
        cand_reg      <= cand_next;
        res_found_reg <= res_found_next;
        res_slot_reg  <= res_slot_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_mem[waddr] <= wdata;
        end
        rd_reg <= tree_mem[raddr];
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign slot      = slot_reg;

endmodule

### design/predecessor_free_slot_allocator_core.sv
// Top level of the predecessor free-slot allocator: controller, datapath and checks.
//
// Hands out slots 1..slot_count, one per request: each position asks for the largest
// free slot at or below it (clamped to slot_count and to SLOTS); that slot is marked
// taken and returned with found = 1, or found = 0 and slot = 0 when none is free.
// Slots come back only through reset. Occupancy and subtree-full summary bits live in
// one single-port-read memory of 2**ceil(log2(SLOTS)) two-bit words, so the walk moves
// one tree level per cycle. A request skips the walk when its bound is zero or the tree
// is full; otherwise it descends the bound path, backtracks into the deepest free left
// subtree when the path is full and then propagates the full bits upward. One request
// is in flight at a time; the next one is taken while the previous result still waits
// in the output register. After reset a clearing pass zeroes every memory word, one
// word a cycle, during which no request is taken; slot_count writes are taken at any time
// and cfg_ready stays high. Write slot_count only while no transaction is in flight.
module predecessor_free_slot_allocator_core #(
    parameter int SLOTS = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pfsa_pkg::POS_W-1:0]     position,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [pfsa_pkg::SLOT_W-1:0]    slot,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pfsa_pkg::COUNT_W-1:0]   slot_count
);

    pfsa_pkg::cmd_t    cmd;
    pfsa_pkg::status_t status;

    // Take the register write whenever it arrives.
    assign cfg_ready = 1'b1;

    pfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pfsa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .position   (position),
        .cfg_valid  (cfg_valid),
        .slot_count (slot_count),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .found      (found),
        .slot       (slot)
    );

`ifndef SYNTHESIS
    // A result carries a nonzero slot exactly when something was allocated.
    a_found_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (found == (slot != '0)))
        else $error("found flag and slot number disagree");

    // Hold off requests while the tree memory is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == pfsa_pkg::OP_CLEAR) |-> !in_ready)
        else $error("request accepted during clearing pass");

    // One transaction at a time: drop ready right after an accept.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request accepted while one is in flight");
`endif

endmodule
